// ===== hdl/mtep_pkg.sv =====
// Shared definitions for the MIDI track event parser.
// Holds field widths, the result kind codes and the variable-length limit.
// No dependencies.
`timescale 1ns / 1ps

package mtep_pkg;

  localparam int unsigned VLQ_MAX_BYTES = 4;
  localparam int unsigned VLQ_W = 28;
  localparam int unsigned POS_W = 32;

  typedef enum logic [1:0] {
    RK_CHANNEL   = 2'd0,
    RK_META_HDR  = 2'd1,
    RK_META_DATA = 2'd2,
    RK_END_TRACK = 2'd3
  } result_kind_e;

  typedef enum logic {
    IK_DATA  = 1'b0,
    IK_START = 1'b1
  } input_kind_e;

  localparam logic [3:0] EV_PROG_CHANGE = 4'hC;
  localparam logic [3:0] EV_CHAN_PRESS  = 4'hD;
  localparam logic [3:0] EV_META        = 4'hF;

endpackage

// ===== hdl/midi_track_event_parser_top.sv =====
// A result is registered into the output register when its byte is accepted.
// Throughput: one byte per cycle while the input is not stalled.
// Input is stalled only while a held result is itself stalled at the output.
// Reset clears the parse state, the position, the track length and the output valid.
// Depends on mtep_pkg.
`timescale 1ns / 1ps

module midi_track_event_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [27:0] delta_time_o,
  output logic [3:0]  event_type_o,
  output logic [3:0]  channel_number_o,
  output logic [7:0]  first_param_o,
  output logic [7:0]  second_param_o,
  output logic [7:0]  meta_type_o,
  output logic [27:0] meta_length_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_o,
  output logic        track_done_o
);

  typedef enum logic [2:0] {
    PH_DELTA   = 3'd0,
    PH_STATUS  = 3'd1,
    PH_PARAM1  = 3'd2,
    PH_PARAM2  = 3'd3,
    PH_MTYPE   = 3'd4,
    PH_MLEN    = 3'd5,
    PH_PAYLOAD = 3'd6
  } phase_e;

  localparam logic [1:0] VlqLastIdx = 2'(mtep_pkg::VLQ_MAX_BYTES - 1);
  localparam logic [mtep_pkg::POS_W-1:0] PosMax = '1;

  phase_e                      phase_q, phase_d;
  logic [1:0]                  vlq_count_q, vlq_count_d;
  logic [mtep_pkg::VLQ_W-1:0]  delta_accum_q, delta_accum_d;
  logic [7:0]                  status_held_q, status_held_d;
  logic [7:0]                  param_held_q, param_held_d;
  logic [7:0]                  meta_type_held_q, meta_type_held_d;
  logic [mtep_pkg::VLQ_W-1:0]  length_accum_q, length_accum_d;
  logic [mtep_pkg::VLQ_W-1:0]  bytes_left_q, bytes_left_d;
  logic [mtep_pkg::POS_W-1:0]  position_q, position_d;
  logic [mtep_pkg::POS_W-1:0]  track_length_q;

  logic                        accept;
  logic                        vlq_done;
  logic [mtep_pkg::VLQ_W-1:0]  delta_base;
  logic [mtep_pkg::VLQ_W-1:0]  bytes_dec;

  logic                        res_valid;
  mtep_pkg::result_kind_e      res_kind;
  logic [7:0]                  res_p1, res_p2, res_pay;
  logic                        res_last;
  logic                        res_meta;
  logic                        res_eot;

  logic                        out_valid_q;
  logic [1:0]                  result_kind_q;
  logic [27:0]                 delta_time_q;
  logic [3:0]                  event_type_q, channel_number_q;
  logic [7:0]                  first_param_q, second_param_q, meta_type_q, payload_byte_q;
  logic [27:0]                 meta_length_q;
  logic                        last_q, track_done_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign vlq_done   = ~data_byte_i[7] | (vlq_count_q == VlqLastIdx);
  assign delta_base = (vlq_count_q == 2'd0) ? '0 : delta_accum_q;
  assign bytes_dec  = bytes_left_q - mtep_pkg::VLQ_W'(1);

  always_comb begin
    phase_d          = phase_q;
    vlq_count_d      = vlq_count_q;
    delta_accum_d    = delta_accum_q;
    status_held_d    = status_held_q;
    param_held_d     = param_held_q;
    meta_type_held_d = meta_type_held_q;
    length_accum_d   = length_accum_q;
    bytes_left_d     = bytes_left_q;
    position_d       = position_q;
    res_valid        = 1'b0;
    res_kind         = mtep_pkg::RK_CHANNEL;
    res_p1           = '0;
    res_p2           = '0;
    res_pay          = '0;
    res_last         = 1'b0;
    res_eot          = 1'b0;

    if (kind_i == mtep_pkg::IK_START) begin
      phase_d          = PH_DELTA;
      vlq_count_d      = '0;
      delta_accum_d    = '0;
      status_held_d    = '0;
      param_held_d     = '0;
      meta_type_held_d = '0;
      length_accum_d   = '0;
      bytes_left_d     = '0;
      position_d       = '0;
    end else if (phase_q == PH_DELTA && vlq_count_q == 2'd0 &&
                 position_q >= track_length_q) begin
      res_valid = 1'b1;
      res_kind  = mtep_pkg::RK_END_TRACK;
      res_last  = 1'b1;
      res_eot   = 1'b1;
    end else begin
      if (position_q != PosMax) begin
        position_d = position_q + mtep_pkg::POS_W'(1);
      end
      case (phase_q)
        PH_DELTA: begin
          delta_accum_d = {delta_base[mtep_pkg::VLQ_W-8:0], data_byte_i[6:0]};
          if (vlq_done) begin
            vlq_count_d = '0;
            phase_d     = PH_STATUS;
          end else begin
            vlq_count_d = vlq_count_q + 2'd1;
          end
        end
        PH_STATUS: begin
          status_held_d = data_byte_i;
          vlq_count_d   = '0;
          phase_d       = (data_byte_i[7:4] == mtep_pkg::EV_META) ? PH_MTYPE : PH_PARAM1;
        end
        PH_PARAM1: begin
          if (status_held_q[7:4] == mtep_pkg::EV_PROG_CHANGE ||
              status_held_q[7:4] == mtep_pkg::EV_CHAN_PRESS) begin
            phase_d   = PH_DELTA;
            res_valid = 1'b1;
            res_p1    = data_byte_i;
            res_last  = 1'b1;
          end else begin
            param_held_d = data_byte_i;
            phase_d      = PH_PARAM2;
          end
        end
        PH_PARAM2: begin
          phase_d   = PH_DELTA;
          res_valid = 1'b1;
          res_p1    = param_held_q;
          res_p2    = data_byte_i;
          res_last  = 1'b1;
        end
        PH_MTYPE: begin
          meta_type_held_d = data_byte_i;
          length_accum_d   = '0;
          vlq_count_d      = '0;
          phase_d          = PH_MLEN;
        end
        PH_MLEN: begin
          length_accum_d = {length_accum_q[mtep_pkg::VLQ_W-8:0], data_byte_i[6:0]};
          if (vlq_done) begin
            vlq_count_d  = '0;
            bytes_left_d = length_accum_d;
            res_valid    = 1'b1;
            res_kind     = mtep_pkg::RK_META_HDR;
            if (length_accum_d == '0) begin
              phase_d  = PH_DELTA;
              res_last = 1'b1;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end else begin
            vlq_count_d = vlq_count_q + 2'd1;
          end
        end
        PH_PAYLOAD: begin
          bytes_left_d = bytes_dec;
          res_valid    = 1'b1;
          res_kind     = mtep_pkg::RK_META_DATA;
          res_pay      = data_byte_i;
          if (bytes_dec == '0) begin
            phase_d  = PH_DELTA;
            res_last = 1'b1;
          end
        end
        default: begin
          phase_d     = PH_DELTA;
          vlq_count_d = '0;
        end
      endcase
    end
  end

  assign res_meta = (res_kind == mtep_pkg::RK_META_HDR) ||
                    (res_kind == mtep_pkg::RK_META_DATA);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_DELTA;
      vlq_count_q      <= '0;
      delta_accum_q    <= '0;
      status_held_q    <= '0;
      param_held_q     <= '0;
      meta_type_held_q <= '0;
      length_accum_q   <= '0;
      bytes_left_q     <= '0;
      position_q       <= '0;
      track_length_q   <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        track_length_q <= cfg_wdata_i;
      end
      if (accept) begin
        phase_q          <= phase_d;
        vlq_count_q      <= vlq_count_d;
        delta_accum_q    <= delta_accum_d;
        status_held_q    <= status_held_d;
        param_held_q     <= param_held_d;
        meta_type_held_q <= meta_type_held_d;
        length_accum_q   <= length_accum_d;
        bytes_left_q     <= bytes_left_d;
        position_q       <= position_d;
      end
      if (accept && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      result_kind_q    <= res_kind;
      delta_time_q     <= res_eot ? '0 : delta_accum_q;
      event_type_q     <= res_eot ? '0 : status_held_q[7:4];
      channel_number_q <= res_eot ? '0 : status_held_q[3:0];
      first_param_q    <= res_p1;
      second_param_q   <= res_p2;
      meta_type_q      <= res_meta ? meta_type_held_q : '0;
      meta_length_q    <= res_meta ? length_accum_d : '0;
      payload_byte_q   <= res_pay;
      last_q           <= res_last;
      track_done_q     <= res_eot | (position_d >= track_length_q);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = result_kind_q;
  assign delta_time_o     = delta_time_q;
  assign event_type_o     = event_type_q;
  assign channel_number_o = channel_number_q;
  assign first_param_o    = first_param_q;
  assign second_param_o   = second_param_q;
  assign meta_type_o      = meta_type_q;
  assign meta_length_o    = meta_length_q;
  assign payload_byte_o   = payload_byte_q;
  assign last_o           = last_q;
  assign track_done_o     = track_done_q;

endmodule

// ===== hdl/mtep_checker.sv =====
// Port-level checks for the MIDI track event parser, bound to its top level.
// Depends on mtep_pkg and midi_track_event_parser_top.
`timescale 1ns / 1ps

module mtep_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  result_kind_o,
  input logic [27:0] delta_time_o,
  input logic [3:0]  event_type_o,
  input logic [3:0]  channel_number_o,
  input logic [7:0]  first_param_o,
  input logic [7:0]  second_param_o,
  input logic [7:0]  meta_type_o,
  input logic [27:0] meta_length_o,
  input logic [7:0]  payload_byte_o,
  input logic        last_o,
  input logic        track_done_o
);

  // An end-of-track transaction carries only its flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == mtep_pkg::RK_END_TRACK |->
      last_o && track_done_o && delta_time_o == '0 && event_type_o == '0 &&
      channel_number_o == '0 && meta_length_o == '0 && payload_byte_o == '0)
    else $error("end of track transaction has stray fields");

  // A channel event is always the final transaction of its event.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == mtep_pkg::RK_CHANNEL |->
      last_o && meta_type_o == '0 && meta_length_o == '0 && payload_byte_o == '0)
    else $error("channel event transaction malformed");

  // A meta header that announces payload is never the final transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == mtep_pkg::RK_META_HDR |->
      (last_o == (meta_length_o == '0)) && first_param_o == '0 && second_param_o == '0)
    else $error("meta header last flag disagrees with its length");

  // A stalled transaction stays on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_kind_o))
    else $error("stalled transaction dropped");

  // The input is held off only by a stalled transaction on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with an empty output");

endmodule

bind midi_track_event_parser_top mtep_checker u_mtep_checker (.*);
